FILE: rtl/bodb_pkg.sv
// Shared types and constants for the Bayer ordered dither binarizer.
`timescale 1ns / 1ps

package bodb_pkg;

    // Pixel channel and channel-sum widths
    localparam int CHAN_W = 8;
    localparam int SUM_W  = 10;

    // Full-scale sum of three channels (3 * 255)
    localparam logic [SUM_W-1:0] LUMA_SCALE = 10'd765;

    // Configuration register widths
    localparam int ORDER_CFG_W = 3;
    localparam int WIDTH_CFG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    // Configuration reset values
    localparam int ORDER_RST = 2;
    localparam int WIDTH_RST = 640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAYER_ORDER = 1'b0,
        CFG_IMAGE_WIDTH = 1'b1
    } t_cfg_idx;

endpackage

FILE: rtl/bodb_pix_if.sv
// Pixel input channel: valid/ready with RGB payload and frame marker.
`timescale 1ns / 1ps

interface bodb_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bodb_pkg::CHAN_W-1:0] red;
    logic [bodb_pkg::CHAN_W-1:0] green;
    logic [bodb_pkg::CHAN_W-1:0] blue;
    logic                        frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, output ready);
endinterface

FILE: rtl/bodb_lvl_if.sv
// Level output channel: valid/ready with the one-bit dithered level.
`timescale 1ns / 1ps

interface bodb_lvl_if;
    logic valid;
    logic ready;
    logic out_level;

    modport source (output valid, output out_level, input ready);
    modport sink   (input valid, input out_level, output ready);
endinterface

FILE: rtl/bodb_pos.sv
// Raster position tracker: column counter and row phase, cleared by frame start.
`timescale 1ns / 1ps

module bodb_pos #(
    parameter int MAX_ORDER = 4,
    parameter int COL_W     = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_frame_start,
    input  logic [COL_W-1:0]     i_last_col,
    output logic [MAX_ORDER-1:0] o_x,
    output logic [MAX_ORDER-1:0] o_y
);

    logic [COL_W-1:0]     r_col, n_col;
    logic [MAX_ORDER-1:0] r_row, n_row;
    logic [COL_W-1:0]     cur_col;
    logic [MAX_ORDER-1:0] cur_row;

    // frame start clears the position before this pixel uses it
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;

    assign o_x = MAX_ORDER'(cur_col);
    assign o_y = cur_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            // >= covers a width shrunk while mid-row
            if (cur_col >= i_last_col) begin
                n_col = '0;
                n_row = cur_row + 1'b1;
            end else begin
                n_col = cur_col + 1'b1;
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: rtl/bodb_thresh.sv
// Threshold compare: Bayer index from cell position, exact integer level test.
`timescale 1ns / 1ps

module bodb_thresh #(
    parameter int MAX_ORDER = 4,
    parameter int ORD_W     = 3
) (
    input  logic [bodb_pkg::CHAN_W-1:0] i_red,
    input  logic [bodb_pkg::CHAN_W-1:0] i_green,
    input  logic [bodb_pkg::CHAN_W-1:0] i_blue,
    input  logic [MAX_ORDER-1:0]        i_x,
    input  logic [MAX_ORDER-1:0]        i_y,
    input  logic [ORD_W-1:0]            i_order,
    output logic                        o_level
);

    localparam int IDX_W = 2 * MAX_ORDER;
    localparam int LW    = IDX_W + bodb_pkg::SUM_W + 1;

    logic [MAX_ORDER-1:0]       x_rev, y_rev, x_sel, y_sel;
    logic [ORD_W-1:0]           rshift;
    logic [IDX_W-1:0]           idx;
    logic [bodb_pkg::SUM_W-1:0] sum;
    logic [ORD_W:0]             lshift;
    logic [LW-1:0]              lhs, rhs;

    // Bit-reverse the cell coordinates, then drop the unused low bits so that
    // x_sel[i] = x[order-1-i]; bits above the order come out zero.
    always_comb begin
        for (int k = 0; k < MAX_ORDER; k++) begin
            x_rev[k] = i_x[MAX_ORDER-1-k];
            y_rev[k] = i_y[MAX_ORDER-1-k];
        end
    end

    assign rshift = ORD_W'(MAX_ORDER) - i_order;
    assign x_sel  = x_rev >> rshift;
    assign y_sel  = y_rev >> rshift;

    always_comb begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            idx[2*i]   = x_sel[i];
            idx[2*i+1] = y_sel[i];
        end
    end

    assign sum = bodb_pkg::SUM_W'(i_red) + bodb_pkg::SUM_W'(i_green)
               + bodb_pkg::SUM_W'(i_blue);

    // 2 * sum * 4^order, shift amount is 2*order+1
    assign lshift = {i_order, 1'b1};
    assign lhs    = LW'(sum) << lshift;
    assign rhs    = LW'(bodb_pkg::LUMA_SCALE) * LW'({idx, 1'b1});

    assign o_level = (lhs > rhs);

endmodule

FILE: rtl/bayer_ordered_dither_binarizer_top.sv
// Bayer ordered dither binarizer: config registers, two-register pixel pipeline.
`timescale 1ns / 1ps
// An accepted pixel beat goes through the input register, then the result register.
// Throughput: one pixel per clock; the input register and result register each
// load whenever the stage ahead is empty or draining, so stalls only back up.
// Reset (sync, active low): position counters clear, bayer_order = 2,
// image_width = 640 (clamped to MAX_ORDER / MAX_WIDTH), pipeline empty.

module bayer_ordered_dither_binarizer_top #(
    parameter int MAX_ORDER = 4,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bodb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bodb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bodb_pix_if.sink                          i_pix,
    bodb_lvl_if.source                        o_lvl
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int CMP_W  = ((COL_W > bodb_pkg::WIDTH_CFG_W) ? COL_W
                                                              : bodb_pkg::WIDTH_CFG_W) + 1;
    localparam int ORD_RST_EFF = (bodb_pkg::ORDER_RST > MAX_ORDER) ? MAX_ORDER
                                                                   : bodb_pkg::ORDER_RST;
    localparam int LAST_RST = ((bodb_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                 : bodb_pkg::WIDTH_RST) - 1;

    // Configuration: stored already clamped
    logic [ORD_W-1:0] r_order, n_order;
    logic [COL_W-1:0] r_last_col, n_last_col;

    logic [bodb_pkg::ORDER_CFG_W-1:0] cfg_ord;
    logic [CMP_W-1:0]                 cfg_w;

    assign cfg_ord = i_cfg_data[bodb_pkg::ORDER_CFG_W-1:0];
    assign cfg_w   = CMP_W'(i_cfg_data[bodb_pkg::WIDTH_CFG_W-1:0]);

    always_comb begin
        n_order    = r_order;
        n_last_col = r_last_col;
        if (i_cfg_we) begin
            case (bodb_pkg::t_cfg_idx'(i_cfg_idx))
                bodb_pkg::CFG_BAYER_ORDER: begin
                    if (cfg_ord > bodb_pkg::ORDER_CFG_W'(MAX_ORDER)) begin
                        n_order = ORD_W'(MAX_ORDER);
                    end else begin
                        n_order = ORD_W'(cfg_ord);
                    end
                end
                bodb_pkg::CFG_IMAGE_WIDTH: begin
                    // zero width acts as one column
                    if (cfg_w == '0) begin
                        n_last_col = '0;
                    end else if (cfg_w > CMP_W'(MAX_WIDTH)) begin
                        n_last_col = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        n_last_col = COL_W'(cfg_w - 1'b1);
                    end
                end
                default: begin
                    n_order    = r_order;
                    n_last_col = r_last_col;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= ORD_W'(ORD_RST_EFF);
            r_last_col <= COL_W'(LAST_RST);
        end else begin
            r_order    <= n_order;
            r_last_col <= n_last_col;
        end
    end

    // Pipeline control
    logic                        r_s1_valid;
    logic                        r_out_valid;
    logic                        s2_load;
    logic                        in_ready;
    logic                        in_beat;

    assign s2_load  = r_s1_valid && (!r_out_valid || o_lvl.ready);
    assign in_ready = !r_s1_valid || s2_load;
    assign in_beat  = i_pix.valid && in_ready;

    assign i_pix.ready = in_ready;

    // Position tracking advances once per accepted pixel
    logic [MAX_ORDER-1:0] pos_x, pos_y;

    bodb_pos #(
        .MAX_ORDER (MAX_ORDER),
        .COL_W     (COL_W)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (in_beat),
        .i_frame_start (i_pix.frame_start),
        .i_last_col    (r_last_col),
        .o_x           (pos_x),
        .o_y           (pos_y)
    );

    // Input register
    logic [bodb_pkg::CHAN_W-1:0] r_s1_red, r_s1_green, r_s1_blue;
    logic [MAX_ORDER-1:0]        r_s1_x, r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_red   <= i_pix.red;
            r_s1_green <= i_pix.green;
            r_s1_blue  <= i_pix.blue;
            r_s1_x     <= pos_x;
            r_s1_y     <= pos_y;
        end
    end

    // Threshold compare between the two registers
    logic level;

    bodb_thresh #(
        .MAX_ORDER (MAX_ORDER),
        .ORD_W     (ORD_W)
    ) u_thresh (
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .i_x     (r_s1_x),
        .i_y     (r_s1_y),
        .i_order (r_order),
        .o_level (level)
    );

    // Result register
    logic r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (o_lvl.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out_level <= level;
        end
    end

    assign o_lvl.valid     = r_out_valid;
    assign o_lvl.out_level = r_out_level;

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for the Bayer ordered dither binarizer: pixel beats vs. predicted levels.
`timescale 1ns / 1ps

module tb_top;
    import bodb_pkg::*;

    localparam int MAX_ORD = 4;
    localparam int MAX_WID = 4096;

    // Tracks raster position and config; holds predicted levels in beat order.
    class dither_scoreboard;
        logic [ORDER_CFG_W-1:0] order_reg;
        logic [WIDTH_CFG_W-1:0] width_reg;
        logic [11:0]            col;
        logic [MAX_ORD-1:0]     row;
        bit                     level_q[$];
        int                     errors;
        int                     beat_cnt;

        function new();
            order_reg = ORDER_CFG_W'(ORDER_RST);
            width_reg = WIDTH_CFG_W'(WIDTH_RST);
            col       = '0;
            row       = '0;
            errors    = 0;
            beat_cnt  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BAYER_ORDER) begin
                order_reg = data[ORDER_CFG_W-1:0];
            end else begin
                order_reg = order_reg;
                width_reg = data[WIDTH_CFG_W-1:0];
            end
        endfunction

        function bit dither_level(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
            int unsigned ord, x, y, v, bp, sum, w, i;
            bit          lvl;
            if (fs) begin
                col = '0;
                row = '0;
            end
            ord = (order_reg > MAX_ORD) ? MAX_ORD : order_reg;
            x   = col & ((1 << ord) - 1);
            y   = row & ((1 << ord) - 1);
            v   = 0;
            // coarsest quadrant bit lands in the lowest base-4 digit
            for (i = 0; i < ord; i++) begin
                bp = ord - 1 - i;
                v  = v + ((((x >> bp) & 1) + 2 * ((y >> bp) & 1)) << (2 * i));
            end
            sum = 32'(r) + 32'(g) + 32'(b);
            lvl = ((2 * sum) << (2 * ord)) > (LUMA_SCALE * (2 * v + 1));
            if (width_reg == 0)
                w = 1;
            else if (width_reg > MAX_WID)
                w = MAX_WID;
            else
                w = 32'(width_reg);
            if (col >= w - 1) begin
                col = '0;
                row = row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
            return lvl;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
            level_q.push_back(dither_level(r, g, b, fs));
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_level(bit got);
            bit exp_lvl;
            beat_cnt++;
            if (level_q.size() == 0) begin
                fail($sformatf("level beat %0d with no pixel pending (got %0d)", beat_cnt, got));
            end else begin
                exp_lvl = level_q.pop_front();
                if (exp_lvl !== got)
                    fail($sformatf("level beat %0d mismatch: expected %0d, got %0d",
                                   beat_cnt, exp_lvl, got));
            end
        endfunction

        function int pending();
            return level_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bodb_pix_if pix ();
    bodb_lvl_if lvl ();

    bayer_ordered_dither_binarizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_lvl      (lvl)
    );

    dither_scoreboard sb = new();

    bit no_idle = 1'b0;
    int rx_hold = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] rand_pixel();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return {c, c, c};
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // level sink: random back-pressure plus an optional long hold
    initial begin
        int rx_gap;
        rx_gap    = 0;
        lvl.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && lvl.valid && lvl.ready) sb.check_level(lvl.out_level);
            if (rx_hold > 0) begin
                rx_hold--;
                lvl.ready <= 1'b0;
            end else begin
                if (rx_gap == 0 && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
                if (rx_gap > 0) begin
                    rx_gap--;
                    lvl.ready <= 1'b0;
                end else begin
                    lvl.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic fs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.red         <= r;
        pix.green       <= g;
        pix.blue        <= b;
        pix.frame_start <= fs;
        do @(posedge i_clk); while (!pix.ready);
        sb.note_pixel(r, g, b, fs);
    endtask

    task automatic send_random(input logic fs);
        logic [23:0] px;
        px = rand_pixel();
        send_pixel(px[23:16], px[15:8], px[7:0], fs);
    endtask

    // stop offering and wait until every predicted level has arrived
    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_set(input logic [CFG_DATA_W-1:0] ord_data,
                           input logic [CFG_DATA_W-1:0] wid_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BAYER_ORDER;
        i_cfg_data <= ord_data;
        @(posedge i_clk);
        sb.write_reg(CFG_BAYER_ORDER, ord_data);
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= wid_data;
        @(posedge i_clk);
        sb.write_reg(CFG_IMAGE_WIDTH, wid_data);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int                    p, k, sel;
        logic [CFG_DATA_W-1:0] ord_data, wid_data;
        logic                  fs;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_BAYER_ORDER;
        i_cfg_data      = '0;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        pix.frame_start = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: order 2, width 640
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0);
        send_pixel(8'd128, 8'd128, 8'd127, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        drain();

        // order zero (half threshold) with zero width
        cfg_set(13'd0, 13'd0);
        send_pixel(8'd128, 8'd128, 8'd127, 1'b1);
        send_pixel(8'd127, 8'd128, 8'd127, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        drain();

        // both fields past their clamps
        cfg_set(13'd7, 13'd8191);
        send_pixel(8'd200, 8'd10,  8'd90,  1'b1);
        send_pixel(8'd1,   8'd2,   8'd3,   1'b0);
        send_pixel(8'd90,  8'd90,  8'd90,  1'b0);
        send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
        drain();

        // width shrinks below the current column mid-row
        cfg_set(13'd3, 13'd10);
        send_random(1'b1);
        repeat (5) send_random(1'b0);
        drain();
        cfg_set(13'd3, 13'd3);
        repeat (3) send_random(1'b0);
        drain();

        for (p = 0; p < 16; p++) begin
            ord_data = {10'($urandom_range(0, 1023)), 3'(p % 8)};
            sel      = $urandom_range(0, 5);
            case (p % 4)
                0: wid_data = 13'($urandom_range(1, 9));
                1: wid_data = 13'($urandom_range(10, 40));
                2: wid_data = 13'($urandom_range(0, 8191));
                default: begin
                    case (sel)
                        0: wid_data = 13'd0;
                        1: wid_data = 13'd1;
                        2: wid_data = 13'd2;
                        3: wid_data = 13'd4096;
                        4: wid_data = 13'd4097;
                        default: wid_data = 13'd8191;
                    endcase
                end
            endcase
            cfg_set(ord_data, wid_data);
            no_idle = (p % 5 == 2);
            if (p == 3) rx_hold = 300;  // output stalls long enough to back up the input
            for (k = 0; k < 100; k++) begin
                if (p == 6 && k == 50) drain();
                if (k == 0)
                    fs = 1'($urandom_range(0, 1));
                else
                    fs = ($urandom_range(0, 63) == 0);
                send_random(fs);
            end
            drain();
        end
        no_idle = 1'b0;

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
